@@ rtl/core/itd_pkg.sv @@
// shared types and constants for the impact and tilt detector
`timescale 1ns / 1ps

package itd_pkg;

    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CMP_W      = 84;
    localparam int PART_W     = 52;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_COS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_HOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_HOLD   = 3'd6;

    localparam logic [31:0] IMPACT_THR_RST  = 32'd806235958;
    localparam logic [9:0]  TILT_COS_RST    = 10'd800;
    localparam logic [15:0] IMPACT_HOLD_RST = 16'd2000;
    localparam logic [15:0] TILT_HOLD_RST   = 16'd3000;

    localparam logic signed [MUL_W-1:0] COS_SCALE_SQ = 33'sd1000000;

    typedef enum logic [3:0] {
        OP_XX,
        OP_YY,
        OP_ZZ,
        OP_XR,
        OP_YR,
        OP_ZR,
        OP_RXX,
        OP_RYY,
        OP_RZZ,
        OP_TT,
        OP_DOT,
        OP_AB,
        OP_D2_LO,
        OP_D2_HI,
        OP_AB_LO,
        OP_AB_HI
    } mul_op_t;

    typedef struct packed {
        logic    valid;
        mul_op_t op;
    } mul_tag_t;

endpackage

@@ rtl/core/impact_and_tilt_detector.sv @@
// top level of the impact and tilt detector: config registers, sequencer, latches
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_ready   | accel_x, accel_y, accel_z, now_ms
//  out     | out_valid / out_ready | impact_event, tilt_event, impact_active, tilt_active
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  a sample makes 16 passes through the shared 33x33 multiplier, then its output
//  register drains, then the decision state runs and the sequencer returns to
//  idle, where the next sample can be accepted
//  the result is registered when the decision state completes; in_ready is low meanwhile
//  a result not yet taken holds the decision cycle until out_ready
//  rst_n clears latches, onset times and the sequencer and loads register defaults
`timescale 1ns / 1ps

module impact_and_tilt_detector
    import itd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    accel_x,
    input  logic signed [15:0]    accel_y,
    input  logic signed [15:0]    accel_z,
    input  logic [31:0]           now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  impact_event,
    output logic                  tilt_event,
    output logic                  impact_active,
    output logic                  tilt_active,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    localparam logic [4:0] LAST_STEP = 5'd16;

    state_t state_reg;
    logic [4:0] step_reg;

    logic signed [15:0] ref_x_reg;
    logic signed [15:0] ref_y_reg;
    logic signed [15:0] ref_z_reg;
    logic [31:0] impact_thr_reg;
    logic [9:0]  tilt_cos_reg;
    logic [15:0] impact_hold_reg;
    logic [15:0] tilt_hold_reg;

    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] z_reg;
    logic [31:0] now_reg;

    logic [31:0]             a_reg;
    logic [31:0]             b_reg;
    logic signed [MUL_W-1:0] dot_reg;
    logic [19:0]             t2_reg;
    logic [63:0]             d2_reg;
    logic [63:0]             ab_reg;
    logic [CMP_W-1:0]        l_reg;
    logic [CMP_W-1:0]        r_reg;

    logic        impact_latched_reg;
    logic        tilt_latched_reg;
    logic [31:0] impact_onset_reg;
    logic [31:0] tilt_onset_reg;

    logic out_valid_reg;
    logic impact_event_reg;
    logic tilt_event_reg;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    mul_tag_t                 issue_tag;
    logic signed [PROD_W-1:0] prod;
    mul_tag_t                 prod_tag;

    logic in_fire;
    logic done_fire;
    logic impact_cond;
    logic tilt_cond;
    logic impact_release;
    logic tilt_release;
    logic [31:0] impact_elapsed;
    logic [31:0] tilt_elapsed;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg       <= '0;
            ref_y_reg       <= '0;
            ref_z_reg       <= '0;
            impact_thr_reg  <= IMPACT_THR_RST;
            tilt_cos_reg    <= TILT_COS_RST;
            impact_hold_reg <= IMPACT_HOLD_RST;
            tilt_hold_reg   <= TILT_HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REF_X:       ref_x_reg       <= cfg_data[15:0];
                CFG_REF_Y:       ref_y_reg       <= cfg_data[15:0];
                CFG_REF_Z:       ref_z_reg       <= cfg_data[15:0];
                CFG_IMPACT_THR:  impact_thr_reg  <= cfg_data;
                CFG_TILT_COS:    tilt_cos_reg    <= cfg_data[9:0];
                CFG_IMPACT_HOLD: impact_hold_reg <= cfg_data[15:0];
                CFG_TILT_HOLD:   tilt_hold_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        issue_tag.valid = (state_reg == S_RUN) && (step_reg < LAST_STEP);
        issue_tag.op    = mul_op_t'(step_reg[3:0]);
        op_a = '0;
        op_b = '0;
        unique case (issue_tag.op)
            OP_XX:    begin op_a = MUL_W'(x_reg);      op_b = MUL_W'(x_reg);      end
            OP_YY:    begin op_a = MUL_W'(y_reg);      op_b = MUL_W'(y_reg);      end
            OP_ZZ:    begin op_a = MUL_W'(z_reg);      op_b = MUL_W'(z_reg);      end
            OP_XR:    begin op_a = MUL_W'(x_reg);      op_b = MUL_W'(ref_x_reg);  end
            OP_YR:    begin op_a = MUL_W'(y_reg);      op_b = MUL_W'(ref_y_reg);  end
            OP_ZR:    begin op_a = MUL_W'(z_reg);      op_b = MUL_W'(ref_z_reg);  end
            OP_RXX:   begin op_a = MUL_W'(ref_x_reg);  op_b = MUL_W'(ref_x_reg);  end
            OP_RYY:   begin op_a = MUL_W'(ref_y_reg);  op_b = MUL_W'(ref_y_reg);  end
            OP_RZZ:   begin op_a = MUL_W'(ref_z_reg);  op_b = MUL_W'(ref_z_reg);  end
            OP_TT:    begin op_a = MUL_W'(tilt_cos_reg); op_b = MUL_W'(tilt_cos_reg); end
            OP_DOT:   begin op_a = dot_reg;            op_b = dot_reg;            end
            OP_AB:    begin op_a = MUL_W'(a_reg);      op_b = MUL_W'(b_reg);      end
            OP_D2_LO: begin op_a = MUL_W'(d2_reg[31:0]);  op_b = COS_SCALE_SQ;    end
            OP_D2_HI: begin op_a = MUL_W'(d2_reg[63:32]); op_b = COS_SCALE_SQ;    end
            OP_AB_LO: begin op_a = MUL_W'(ab_reg[31:0]);  op_b = MUL_W'(t2_reg);  end
            OP_AB_HI: begin op_a = MUL_W'(ab_reg[63:32]); op_b = MUL_W'(t2_reg);  end
            default:  ;
        endcase
    end

    itd_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_a     (op_a),
        .op_b     (op_b),
        .tag      (issue_tag),
        .prod     (prod),
        .prod_tag (prod_tag)
    );

    // sample capture and accumulation of products
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg   <= accel_x;
            y_reg   <= accel_y;
            z_reg   <= accel_z;
            now_reg <= now_ms;
            a_reg   <= '0;
            b_reg   <= '0;
            dot_reg <= '0;
        end
        else if (prod_tag.valid)
        begin
            unique case (prod_tag.op)
                OP_XX, OP_YY, OP_ZZ:    a_reg   <= a_reg + prod[31:0];
                OP_XR, OP_YR, OP_ZR:    dot_reg <= dot_reg + $signed(prod[MUL_W-1:0]);
                OP_RXX, OP_RYY, OP_RZZ: b_reg   <= b_reg + prod[31:0];
                OP_TT:                  t2_reg  <= prod[19:0];
                OP_DOT:                 d2_reg  <= prod[63:0];
                OP_AB:                  ab_reg  <= prod[63:0];
                OP_D2_LO:               l_reg   <= CMP_W'(prod[PART_W-1:0]);
                OP_D2_HI:               l_reg   <= l_reg + {prod[PART_W-1:0], 32'd0};
                OP_AB_LO:               r_reg   <= CMP_W'(prod[PART_W-1:0]);
                OP_AB_HI:               r_reg   <= r_reg + {prod[PART_W-1:0], 32'd0};
                default:                ;
            endcase
        end
    end

    // decision
    always_comb
    begin
        impact_cond    = a_reg > impact_thr_reg;
        tilt_cond      = (a_reg != '0) && (b_reg != '0) && (dot_reg < 0 || l_reg < r_reg);
        impact_elapsed = now_reg - impact_onset_reg;
        tilt_elapsed   = now_reg - tilt_onset_reg;
        impact_release = impact_latched_reg && (impact_elapsed > 32'(impact_hold_reg));
        tilt_release   = tilt_latched_reg && (tilt_elapsed > 32'(tilt_hold_reg));
    end

    // sequencer, latches and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            step_reg           <= '0;
            impact_latched_reg <= 1'b0;
            tilt_latched_reg   <= 1'b0;
            impact_onset_reg   <= '0;
            tilt_onset_reg     <= '0;
            out_valid_reg      <= 1'b0;
            impact_event_reg   <= 1'b0;
            tilt_event_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !done_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_RUN;
                        step_reg  <= '0;
                    end
                end
                S_RUN:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        state_reg        <= S_IDLE;
                        out_valid_reg    <= 1'b1;
                        impact_event_reg <= impact_cond && !impact_latched_reg;
                        tilt_event_reg   <= tilt_cond && !tilt_latched_reg;
                        if (impact_cond && !impact_latched_reg)
                        begin
                            impact_latched_reg <= 1'b1;
                            impact_onset_reg   <= now_reg;
                        end
                        else if (!impact_cond && impact_release)
                        begin
                            impact_latched_reg <= 1'b0;
                        end
                        if (tilt_cond && !tilt_latched_reg)
                        begin
                            tilt_latched_reg <= 1'b1;
                            tilt_onset_reg   <= now_reg;
                        end
                        else if (!tilt_cond && tilt_release)
                        begin
                            tilt_latched_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign impact_event  = impact_event_reg;
    assign tilt_event    = tilt_event_reg;
    assign impact_active = impact_latched_reg;
    assign tilt_active   = tilt_latched_reg;

    a_event_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!impact_event || impact_active) && (!tilt_event || tilt_active)))
        else $error("event raised without its latch set");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the decision cycle");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_RUN && step_reg == '0))
        else $error("accepted transaction did not start the sequencer");

    a_product_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        prod_tag.valid |-> (state_reg == S_RUN))
        else $error("multiplier product outside the run phase");

endmodule

@@ rtl/core/itd_mul.sv @@
// registered signed multiplier with tag carried alongside the product
`timescale 1ns / 1ps

module itd_mul
    import itd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    input  mul_tag_t                 tag,
    output logic signed [PROD_W-1:0] prod,
    output mul_tag_t                 prod_tag
);

    logic signed [PROD_W-1:0] prod_reg;
    mul_tag_t                 tag_reg;

    always_ff @(posedge clk)
    begin
        if (tag.valid)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    assign prod     = prod_reg;
    assign prod_tag = tag_reg;

endmodule

@@ dv/itd_alarm_checker.sv @@
// alarm predictor and result checker for the impact and tilt detector
`timescale 1ns / 1ps

module itd_alarm_checker
    import itd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic signed [15:0]    accel_x,
    input  logic signed [15:0]    accel_y,
    input  logic signed [15:0]    accel_z,
    input  logic [31:0]           now_ms,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  impact_event,
    input  logic                  tilt_event,
    input  logic                  impact_active,
    input  logic                  tilt_active,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic impact_event;
        logic tilt_event;
        logic impact_active;
        logic tilt_active;
    } alarm_t;

    logic signed [15:0] ref_x_q;
    logic signed [15:0] ref_y_q;
    logic signed [15:0] ref_z_q;
    logic [31:0]        impact_thr_q;
    logic [9:0]         tilt_cos_q;
    logic [15:0]        impact_hold_q;
    logic [15:0]        tilt_hold_q;

    logic               impact_latched;
    logic               tilt_latched;
    logic [31:0]        impact_onset;
    logic [31:0]        tilt_onset;

    alarm_t             pending_alarms[$];
    int                 mismatches;

    assign fail_count = mismatches;

    function automatic logic [63:0] mag_sq(input logic signed [15:0] x, y, z);
        longint sx;
        longint sy;
        longint sz;
        sx = x;
        sy = y;
        sz = z;
        return 64'(sx * sx + sy * sy + sz * sz);
    endfunction

    // exact cosine test: 1000*dot < t*|a|*|b| without square roots
    function automatic logic tilt_present(input logic signed [15:0] x, y, z);
        logic [63:0]  a2;
        logic [63:0]  b2;
        logic [63:0]  ud;
        longint       dot;
        logic [127:0] lhs;
        logic [127:0] rhs;
        a2 = mag_sq(x, y, z);
        b2 = mag_sq(ref_x_q, ref_y_q, ref_z_q);
        if (a2 == 0 || b2 == 0)
            return 1'b0;
        dot = longint'(x) * longint'(ref_x_q) + longint'(y) * longint'(ref_y_q)
            + longint'(z) * longint'(ref_z_q);
        if (dot < 0)
            return 1'b1;
        if (dot == 0)
            return tilt_cos_q != 0;
        ud  = 64'(dot);
        lhs = 128'(ud) * 128'(ud) * 128'd1000000;
        rhs = 128'(a2) * 128'(b2) * 128'(tilt_cos_q) * 128'(tilt_cos_q);
        return lhs < rhs;
    endfunction

    function automatic alarm_t predict_alarm(input logic signed [15:0] x, y, z,
                                             input logic [31:0] t_ms);
        alarm_t res;
        res = '0;
        if (mag_sq(x, y, z) > 64'(impact_thr_q))
        begin
            if (!impact_latched)
            begin
                impact_latched   = 1'b1;
                impact_onset     = t_ms;
                res.impact_event = 1'b1;
            end
        end
        else if (impact_latched && (t_ms - impact_onset) > 32'(impact_hold_q))
            impact_latched = 1'b0;

        if (tilt_present(x, y, z))
        begin
            if (!tilt_latched)
            begin
                tilt_latched   = 1'b1;
                tilt_onset     = t_ms;
                res.tilt_event = 1'b1;
            end
        end
        else if (tilt_latched && (t_ms - tilt_onset) > 32'(tilt_hold_q))
            tilt_latched = 1'b0;

        res.impact_active = impact_latched;
        res.tilt_active   = tilt_latched;
        return res;
    endfunction

    task automatic check_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        alarm_t want;
        if (!rst_n)
        begin
            ref_x_q        = '0;
            ref_y_q        = '0;
            ref_z_q        = '0;
            impact_thr_q   = IMPACT_THR_RST;
            tilt_cos_q     = TILT_COS_RST;
            impact_hold_q  = IMPACT_HOLD_RST;
            tilt_hold_q    = TILT_HOLD_RST;
            impact_latched = 1'b0;
            tilt_latched   = 1'b0;
            impact_onset   = '0;
            tilt_onset     = '0;
            pending_alarms.delete();
            mismatches     = 0;
            pending       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REF_X:       ref_x_q       = cfg_data[15:0];
                    CFG_REF_Y:       ref_y_q       = cfg_data[15:0];
                    CFG_REF_Z:       ref_z_q       = cfg_data[15:0];
                    CFG_IMPACT_THR:  impact_thr_q  = cfg_data[31:0];
                    CFG_TILT_COS:    tilt_cos_q    = cfg_data[9:0];
                    CFG_IMPACT_HOLD: impact_hold_q = cfg_data[15:0];
                    CFG_TILT_HOLD:   tilt_hold_q   = cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                pending_alarms.push_back(predict_alarm(accel_x, accel_y, accel_z, now_ms));

            if (out_valid && out_ready)
            begin
                if (pending_alarms.size() == 0)
                begin
                    $error("alarm transaction with no sample outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_alarms.pop_front();
                    check_field("impact_event", want.impact_event, impact_event);
                    check_field("tilt_event", want.tilt_event, tilt_event);
                    check_field("impact_active", want.impact_active, impact_active);
                    check_field("tilt_active", want.tilt_active, tilt_active);
                end
            end

            pending <= pending_alarms.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// stimulus and verdict for the impact and tilt detector testbench
`timescale 1ns / 1ps

module testbench;

    import itd_pkg::*;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 1_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    accel_x   = '0;
    logic signed [15:0]    accel_y   = '0;
    logic signed [15:0]    accel_z   = '0;
    logic [31:0]           now_ms    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  impact_event;
    logic                  tilt_event;
    logic                  impact_active;
    logic                  tilt_active;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int tx_idle_pct = 6;
    int rx_idle_pct = 50;
    int cycle_count = 0;

    impact_and_tilt_detector dut (.*);

    itd_alarm_checker alarm_check (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_sample(input logic signed [15:0] x, y, z, input logic [31:0] t_ms);
        int gap;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(9) == 0)
            gap = $urandom_range(1, 25);
        else
            while (gap < 40 && $urandom_range(99) < tx_idle_pct)
                gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        now_ms   <= t_ms;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // unused upper data bits carry noise, the block must ignore them
    task automatic program_detector(input logic signed [15:0] rx, ry, rz,
                                    input logic [31:0] thr, input logic [9:0] cos_pm,
                                    input logic [15:0] ihold, thold);
        write_reg(CFG_REF_X, {16'($urandom), rx});
        write_reg(CFG_REF_Y, {16'($urandom), ry});
        write_reg(CFG_REF_Z, {16'($urandom), rz});
        write_reg(CFG_IMPACT_THR, thr);
        write_reg(CFG_TILT_COS, {22'($urandom), cos_pm});
        write_reg(CFG_IMPACT_HOLD, {16'($urandom), ihold});
        write_reg(CFG_TILT_HOLD, {16'($urandom), thold});
        write_reg(CFG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int                 phase;
        int                 n;
        int                 k;
        int                 kind;
        int                 shift;
        logic signed [15:0] s [3];
        logic signed [15:0] ref_vec [3];
        logic [31:0]        thr;
        logic [9:0]         cos_pm;
        logic [15:0]        ihold;
        logic [15:0]        thold;
        logic [31:0]        step;
        logic [31:0]        clock_ms;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: zero reference, impact onset, hold and release
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd10);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd20);
        send_sample(16'sd0, 16'sd0, 16'sd100, 32'd2010);
        send_sample(16'sd0, 16'sd0, 16'sd100, 32'd2011);
        wait_drained();

        // orthogonal, opposite and zero samples, onset across the time wrap
        program_detector(16'sd0, 16'sd0, 16'sd16384, IMPACT_THR_RST, TILT_COS_RST,
                         16'd5, 16'd7);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 32'd100);
        send_sample(16'sd16384, 16'sd0, 16'sd0, 32'hFFFF_FFFC);
        send_sample(16'sd0, 16'sd0, -16'sd16384, 32'hFFFF_FFFE);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd2);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd4);
        send_sample(16'sd16384, 16'sd0, 16'sd16384, 32'd5);
        wait_drained();

        // zero threshold, zero permille, zero holds
        program_detector(16'sh8000, 16'sh7FFF, 16'sd0, 32'd0, 10'd0, 16'd0, 16'd0);
        send_sample(16'sd0, 16'sd0, 16'sd5, 32'd10);
        send_sample(16'sd1, 16'sd1, 16'sd0, 32'd10);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd10);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd11);
        wait_drained();

        // permille above 1000, threshold equal to the largest magnitude
        program_detector(16'sh8000, 16'sh7FFF, 16'sd0, 32'd3221225472, 10'd1023,
                         16'd0, 16'd0);
        send_sample(16'sh8000, 16'sh7FFF, 16'sd0, 32'd20);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd21);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd30);
        wait_drained();

        program_detector(16'sd0, 16'sd0, 16'sd0, IMPACT_THR_RST, TILT_COS_RST,
                         16'd3, 16'd3);
        send_sample(16'sd100, -16'sd200, 16'sd300, 32'd40);
        wait_drained();

        clock_ms = 32'hFFFF_F000;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 2)
            begin
                tx_idle_pct = 6;
                rx_idle_pct = 50;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 50;
                rx_idle_pct = 6;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (phase == 0)
            begin
                for (k = 0; k < 3; k++)
                    ref_vec[k] = 16'sh8000;
                thr    = 32'd0;
                cos_pm = 10'd0;
                ihold  = 16'd0;
                thold  = 16'd0;
            end
            else if (phase == 1)
            begin
                for (k = 0; k < 3; k++)
                    ref_vec[k] = 16'sh7FFF;
                thr    = 32'd3221225472;
                cos_pm = 10'd1023;
                ihold  = 16'hFFFF;
                thold  = 16'hFFFF;
            end
            else
            begin
                for (k = 0; k < 3; k++)
                    ref_vec[k] = ($urandom_range(9) == 0) ? 16'sd0 : 16'($urandom);
                thr    = ($urandom_range(1) == 0) ? $urandom_range(0, 8_000_000)
                                                  : $urandom_range(0, 32'd3221225472);
                cos_pm = ($urandom_range(1) == 0) ? 10'($urandom_range(600, 1000))
                                                  : 10'($urandom_range(0, 1023));
                ihold  = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
                thold  = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
            end
            program_detector(ref_vec[0], ref_vec[1], ref_vec[2], thr, cos_pm, ihold, thold);

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                kind  = $urandom_range(99);
                shift = $urandom_range(0, 3);
                for (k = 0; k < 3; k++)
                begin
                    if (kind < 35)
                    begin
                        // near the reference direction, sometimes reversed
                        s[k] = ref_vec[k] >>> shift;
                        s[k] = s[k] + 16'($urandom_range(0, 1023)) - 16'd512;
                        if (kind < 10)
                            s[k] = -s[k];
                    end
                    else if (kind < 65)
                        s[k] = 16'($urandom);
                    else if (kind < 85)
                        s[k] = 16'($urandom_range(0, 4000)) - 16'd2000;
                    else
                    begin
                        case ($urandom_range(4))
                            0:       s[k] = 16'sh8000;
                            1:       s[k] = 16'sh7FFF;
                            2:       s[k] = 16'sd0;
                            3:       s[k] = 16'sd1;
                            default: s[k] = -16'sd1;
                        endcase
                    end
                end

                kind = $urandom_range(99);
                if (kind < 70)
                    step = $urandom_range(0, 64);
                else if (kind < 92)
                    step = $urandom_range(0, 70000);
                else
                    step = $urandom();
                clock_ms = clock_ms + step;

                send_sample(s[0], s[1], s[2], clock_ms);

                if (n == ITEMS_PER_PHASE / 2 || $urandom_range(199) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/itd_pkg.sv
rtl/core/itd_mul.sv
rtl/core/impact_and_tilt_detector.sv
dv/itd_alarm_checker.sv
dv/testbench.sv
